@@ hdl/lbp3x3_pkg.sv @@
// Constants and types shared by the 3x3 local binary pattern block.
package lbp3x3_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int DIM_BITS   = 13;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DIM_BITS-1:0] MIN_DIM       = DIM_BITS'(3);
    localparam logic [DIM_BITS-1:0] MAX_WIDTH_V   = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] MAX_HEIGHT_V  = DIM_BITS'(MAX_HEIGHT);
    localparam logic [DIM_BITS-1:0] WIDTH_RESET   = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET  = DIM_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_index_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COL_BITS-1:0]    col_t;
    typedef logic [ROW_BITS-1:0]    row_t;

    // Code bit for each neighbour, neighbours taken row by row, centre skipped.
    localparam logic [2:0] BIT_OF_POS [8] = '{
        3'd3, 3'd2, 3'd1, 3'd4, 3'd0, 3'd5, 3'd6, 3'd7
    };

    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS-1:0] hi
    );
        logic [DIM_BITS-1:0] r;
        begin
            if (v < MIN_DIM) begin
                r = MIN_DIM;
            end else if (v > hi) begin
                r = hi;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

@@ hdl/local_binary_pattern_3x3.sv @@
// Top level: 3x3 local binary pattern over a raster stream of depth pixels.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | depth_sample, frame_start
//  m_      | out       | m_valid / m_ready  | pattern_code, center_col, center_row, frame_done
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One pixel per cycle sustained while m_ready does not hold the output; a code
// reaches m_ after its pixel is accepted (line store read, then window and output register).
// Both previous rows sit in one line store entry per column, read at accept
// and written back when the window stage fires; a same-column read is forwarded.
// Reset clears counters, window and valids; the line store is not cleared.
// A held output stalls the window stage, which then drops s_ready.
module local_binary_pattern_3x3 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [15:0]                   s_depth_sample,
    input  logic                          s_frame_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_pattern_code,
    output logic [11:0]                   m_center_col,
    output logic [11:0]                   m_center_row,
    output logic                          m_frame_done,
    input  logic                          cfg_wr_en,
    input  logic [lbp3x3_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [lbp3x3_pkg::DIM_BITS-1:0]     cfg_wr_data
);
    import lbp3x3_pkg::*;

    // configuration
    logic [DIM_BITS-1:0] line_width_reg, frame_height_reg;
    logic [DIM_BITS-1:0] w_eff, h_eff, last_col, last_row;

    // counters
    col_t col_count_reg, col_count_next;
    row_t row_count_reg, row_count_next;
    col_t c_cur;
    row_t r_cur;

    // line store: {row r-2, row r-1} per column
    logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;
    logic [2*SAMPLE_BITS-1:0] fwd_data_reg;
    logic                     fwd_reg;
    logic [2*SAMPLE_BITS-1:0] line_word;

    // window stage
    logic    s1_valid_reg, s1_result_reg, s1_done_reg;
    col_t    s1_col_reg;
    row_t    s1_row_reg;
    sample_t s1_pix_reg;
    sample_t win_reg [3][3];
    sample_t top_s, mid_s, centre;
    sample_t nb [8];
    logic [7:0] code;

    // output register
    logic       m_valid_reg;
    logic [7:0] m_code_reg;
    col_t       m_col_reg;
    row_t       m_row_reg;
    logic       m_done_reg;

    logic advance, s1_fire, s_accept, fwd_hit;

    assign w_eff    = clamp_dim(line_width_reg, MAX_WIDTH_V);
    assign h_eff    = clamp_dim(frame_height_reg, MAX_HEIGHT_V);
    assign last_col = w_eff - DIM_BITS'(1);
    assign last_row = h_eff - DIM_BITS'(1);

    assign advance  = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign s_ready  = !s1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        c_cur = s_frame_start ? '0 : col_count_reg;
        r_cur = s_frame_start ? '0 : row_count_reg;
        if (DIM_BITS'(c_cur) >= last_col) begin
            col_count_next = '0;
            row_count_next = (DIM_BITS'(r_cur) >= last_row) ? '0 : r_cur + ROW_BITS'(1);
        end else begin
            col_count_next = c_cur + COL_BITS'(1);
            row_count_next = r_cur;
        end
    end

    // same column written back by the window stage in the cycle of this read
    assign fwd_hit = s1_fire && (c_cur == s1_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_wr_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // line store read port
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= line_mem[c_cur];
        end
    end

    // line store write port: row r-1 moves up, the new pixel becomes row r-1
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            line_mem[s1_col_reg] <= {mid_s, s1_pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_reg <= fwd_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_data_reg <= {mid_s, s1_pix_reg};
        end
    end

    assign line_word = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign top_s     = line_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign mid_s     = line_word[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_col_reg    <= c_cur;
            s1_row_reg    <= r_cur;
            s1_pix_reg    <= s_depth_sample[SAMPLE_BITS-1:0];
            s1_result_reg <= (r_cur >= ROW_BITS'(2)) && (c_cur >= COL_BITS'(2));
            s1_done_reg   <= (DIM_BITS'(r_cur) == last_row) && (DIM_BITS'(c_cur) == last_col);
        end
    end

    // window after the shift, as the code sees it
    always_comb begin
        centre = win_reg[1][2];
        nb[0] = win_reg[0][1];
        nb[1] = win_reg[0][2];
        nb[2] = top_s;
        nb[3] = win_reg[1][1];
        nb[4] = mid_s;
        nb[5] = win_reg[2][1];
        nb[6] = win_reg[2][2];
        nb[7] = s1_pix_reg;
        code = '0;
        for (int p = 0; p < 8; p++) begin
            if (nb[p] > centre) begin
                code[BIT_OF_POS[p]] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (s1_fire) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_s;
            win_reg[1][2] <= mid_s;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_result_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_result_reg) begin
            m_code_reg <= code;
            m_col_reg  <= s1_col_reg - COL_BITS'(1);
            m_row_reg  <= s1_row_reg - ROW_BITS'(1);
            m_done_reg <= s1_done_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pattern_code = m_code_reg;
    assign m_center_col   = 12'(m_col_reg);
    assign m_center_row   = 12'(m_row_reg);
    assign m_frame_done   = m_done_reg;

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !advance) |-> !s_ready)
        else $error("request accepted while window stage is stalled");

    a_fwd_needs_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (fwd_reg && !$past(fwd_reg)) |-> $past(s_accept))
        else $error("forward flag set without a line store read");

    a_frame_start_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_accept && s_frame_start) |=> (col_count_reg == COL_BITS'(1)))
        else $error("column counter not restarted by frame start");

    a_interior_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_col_reg != '0 && m_row_reg != '0))
        else $error("code emitted for a border pixel");
`endif

endmodule
